>>> sv/kcdf_pkg.sv
package kcdf_pkg;

    // Table geometry and field widths
    localparam int SLOT_COUNT = 24;
    localparam int KEY_BITS = 64;
    localparam int TIME_BITS = 48;
    localparam int HOLD_BITS = 16;
    localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_OUT_BITS = 5;
    localparam logic [HOLD_BITS-1:0] HOLD_RESET = 16'd250;

    // Stream payload layout
    localparam int S_FIELD_BITS = KEY_BITS + TIME_BITS + 2;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int KEY_LSB = 0;
    localparam int TIME_LSB = KEY_BITS;
    localparam int KNOWN_POS = KEY_BITS + TIME_BITS;
    localparam int ON_POS = KEY_BITS + TIME_BITS + 1;
    localparam int M_FIELD_BITS = SLOT_OUT_BITS + 2;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [TIME_BITS-1:0] time_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  empty;
        key_t  key;
        time_t now;
        logic  known;
        logic  on;
        logic  hit;
        idx_t  hit_idx;
        time_t hit_time;
        logic  hit_known;
        logic  hit_on;
        logic  have_free;
        idx_t  vacant_idx;
        logic  have_old;
        time_t old_time;
        idx_t  old_idx;
    } probe_t;

    // Entry write broadcast to every cell
    typedef struct packed {
        logic  en;
        idx_t  idx;
        key_t  key;
        time_t last_time;
        logic  known;
        logic  on;
    } wr_t;

endpackage

>>> sv/kcdf_cell.sv
module kcdf_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  kcdf_pkg::idx_t   cell_idx,
    input  kcdf_pkg::probe_t probe_in,
    input  kcdf_pkg::wr_t    wr,
    output kcdf_pkg::probe_t probe_out
);

    logic              used_reg;
    kcdf_pkg::key_t    key_reg;
    kcdf_pkg::time_t   time_reg;
    logic              known_reg;
    logic              on_reg;
    logic              pvalid_reg;
    kcdf_pkg::probe_t  probe_reg;
    kcdf_pkg::probe_t  probe_next;
    logic              wr_here;

    assign wr_here = wr.en && (wr.idx == cell_idx);

    // Hold one table entry; take the broadcast write addressed here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (wr_here) begin
            used_reg <= 1'b1;
        end
        if (wr_here) begin
            key_reg   <= wr.key;
            time_reg  <= wr.last_time;
            known_reg <= wr.known;
            on_reg    <= wr.on;
        end
    end

    // Fold this entry into the passing search record
    always_comb begin
        probe_next = probe_in;
        if (!used_reg) begin
            if (!probe_in.have_free) begin
                probe_next.have_free  = 1'b1;
                probe_next.vacant_idx = cell_idx;
            end
        end else if (!probe_in.hit) begin
            if (key_reg == probe_in.key) begin
                probe_next.hit       = 1'b1;
                probe_next.hit_idx   = cell_idx;
                probe_next.hit_time  = time_reg;
                probe_next.hit_known = known_reg;
                probe_next.hit_on    = on_reg;
            end else if (!probe_in.have_old || (time_reg < probe_in.old_time)) begin
                probe_next.have_old = 1'b1;
                probe_next.old_time = time_reg;
                probe_next.old_idx  = cell_idx;
            end
        end
    end

    // Advance the record to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= probe_in.valid;
        end
        probe_reg <= probe_next;
    end

    always_comb begin
        probe_out       = probe_reg;
        probe_out.valid = pvalid_reg;
    end

endmodule

>>> sv/kcdf_chain.sv
module kcdf_chain (
    input  logic             aclk,
    input  logic             aresetn,
    input  kcdf_pkg::probe_t probe_in,
    input  kcdf_pkg::wr_t    wr,
    output kcdf_pkg::probe_t probe_out
);

    kcdf_pkg::probe_t link [kcdf_pkg::SLOT_COUNT+1];

    assign link[0] = probe_in;

    // One cell per table slot, lowest index first
    for (genvar i = 0; i < kcdf_pkg::SLOT_COUNT; i++) begin : g_cell
        kcdf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (kcdf_pkg::IDX_BITS'(i)),
            .probe_in  (link[i]),
            .wr        (wr),
            .probe_out (link[i+1])
        );
    end

    assign probe_out = link[kcdf_pkg::SLOT_COUNT];

endmodule

>>> sv/keyed_command_duplicate_filter_unit.sv
// Duplicate filter for keyed on/off commands. Each command is looked up in a table of
// SLOT_COUNT entries held in a row of cells; a search record walks the row one cell per
// cycle, picking up a key match, the lowest free slot and the oldest entry. A repeat of a
// known, equal target younger than the hold window is dropped (allow=0); any other match
// refreshes the entry, and a miss fills the lowest free slot or replaces the oldest one.
// An empty key gives allow=0, matched=0, slot_index=0 and leaves the table untouched.
// One result per command. The cell row is walked by one command at a time, so a command
// occupies the block from acceptance until its decision is loaded into the output
// register, and only then can the next one be taken: it is launched, passes each cell,
// is captured and is decided; the entry write overlaps the next acceptance. A finished
// result waits in the output register without holding up the next command. The hold
// window register resets to 250 ms and may be written at any time the block is idle.
module keyed_command_duplicate_filter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cfg_data: hold_window_ms[15:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcdf_pkg::HOLD_BITS-1:0]    cfg_data,
    // s_tdata: entity_key[63:0], now_ms[111:64], power_known[112], power_on[113], zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kcdf_pkg::S_TDATA_BITS-1:0] s_tdata,
    // s_tuser: key_empty[0]
    input  logic                              s_tuser,
    // m_tdata: allow[0], matched[1], slot_index[6:2], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kcdf_pkg::M_TDATA_BITS-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                            state_reg;
    logic [kcdf_pkg::HOLD_BITS-1:0]    hold_reg;
    logic                              launch_reg;
    kcdf_pkg::probe_t                  launch_probe_reg;
    kcdf_pkg::probe_t                  launch_probe_next;
    kcdf_pkg::probe_t                  chain_in;
    kcdf_pkg::probe_t                  chain_out;
    kcdf_pkg::probe_t                  end_reg;
    kcdf_pkg::wr_t                     wr_reg;
    kcdf_pkg::wr_t                     wr_next;
    logic                              m_tvalid_reg;
    logic [kcdf_pkg::M_TDATA_BITS-1:0] m_tdata_reg;
    logic [kcdf_pkg::M_TDATA_BITS-1:0] m_tdata_next;
    logic                              s_fire;
    logic                              out_free;
    logic                              result_load;
    kcdf_pkg::time_t                   age;
    logic                              recent;
    logic                              same;
    logic                              allow;
    logic                              matched;
    kcdf_pkg::idx_t                    slot;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign result_load = (state_reg == ST_DECIDE) && out_free;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;

    // Hold window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= kcdf_pkg::HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hold_reg <= cfg_data;
        end
    end

    // Unpack the accepted transaction into a fresh search record
    always_comb begin
        launch_probe_next       = '0;
        launch_probe_next.empty = s_tuser;
        launch_probe_next.key   = s_tdata[kcdf_pkg::KEY_LSB +: kcdf_pkg::KEY_BITS];
        launch_probe_next.now   = s_tdata[kcdf_pkg::TIME_LSB +: kcdf_pkg::TIME_BITS];
        launch_probe_next.known = s_tdata[kcdf_pkg::KNOWN_POS];
        launch_probe_next.on    = s_tdata[kcdf_pkg::ON_POS];
    end

    // Launch record for the cell row
    always_comb begin
        chain_in       = launch_probe_reg;
        chain_in.valid = launch_reg;
    end

    kcdf_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .probe_in  (chain_in),
        .wr        (wr_reg),
        .probe_out (chain_out)
    );

    // Decide on the finished search
    always_comb begin
        age     = end_reg.now - end_reg.hit_time;
        recent  = (end_reg.now < end_reg.hit_time) ||
                  (age < kcdf_pkg::TIME_BITS'(hold_reg));
        same    = end_reg.known && end_reg.hit_known && (end_reg.hit_on == end_reg.on);
        wr_next = '0;
        wr_next.key       = end_reg.key;
        wr_next.last_time = end_reg.now;
        wr_next.known     = end_reg.known;
        wr_next.on        = end_reg.on;
        allow   = 1'b1;
        matched = 1'b0;
        slot    = '0;
        if (end_reg.empty) begin
            allow = 1'b0;
        end else if (end_reg.hit) begin
            matched = 1'b1;
            slot    = end_reg.hit_idx;
            if (same && recent) begin
                allow = 1'b0;
            end else begin
                wr_next.en  = 1'b1;
                wr_next.idx = end_reg.hit_idx;
            end
        end else begin
            slot        = end_reg.have_free ? end_reg.vacant_idx : end_reg.old_idx;
            wr_next.en  = 1'b1;
            wr_next.idx = slot;
        end
        m_tdata_next = kcdf_pkg::M_TDATA_BITS'({kcdf_pkg::SLOT_OUT_BITS'(slot), matched, allow});
    end

    // Sequencer: launch, scan the row, decide and write back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            wr_reg.en    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            launch_reg   <= s_fire;
            wr_reg.en    <= result_load && wr_next.en;
            m_tvalid_reg <= result_load || (m_tvalid_reg && !m_tready);
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (chain_out.valid) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (s_fire) begin
            launch_probe_reg <= launch_probe_next;
        end
        if ((state_reg == ST_SCAN) && chain_out.valid) begin
            end_reg <= chain_out;
        end
        if (result_load) begin
            m_tdata_reg      <= m_tdata_next;
            wr_reg.idx       <= wr_next.idx;
            wr_reg.key       <= wr_next.key;
            wr_reg.last_time <= wr_next.last_time;
            wr_reg.known     <= wr_next.known;
            wr_reg.on        <= wr_next.on;
        end
    end

    // An accepted command launches a search record on the next cycle
    a_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (launch_reg && (state_reg == ST_SCAN)))
        else $error("search record not launched after accepted transaction");

    // A table write follows only a decision, and never for an empty key
    a_write_after_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg.en |-> ($past(state_reg) == ST_DECIDE) && !end_reg.empty)
        else $error("table write without a decision");

    // A new result appears only out of the decide step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DECIDE))
        else $error("result produced outside the decide step");

    // A dropped repeat never writes the table
    a_drop_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && out_free && !allow) |=> !wr_reg.en)
        else $error("dropped or rejected command wrote the table");

endmodule

>>> tb/tb_keyed_command_duplicate_filter_unit.sv
`timescale 1ns / 1ps

module tb_keyed_command_duplicate_filter_unit;
    import kcdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 3);
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 208;
    localparam int KEY_POOL = 32;

    typedef struct {
        key_t  key;
        logic  empty;
        time_t now;
        logic  known;
        logic  on;
    } command_t;

    typedef struct {
        logic                     allow;
        logic                     matched;
        logic [SLOT_OUT_BITS-1:0] slot;
    } verdict_t;

    typedef struct {
        command_t cmd;
        bit       typed;
        verdict_t want;
    } row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [HOLD_BITS-1:0]    cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // Shadow copy of the slot table and the hold window
    bit                   tbl_used [SLOT_COUNT];
    key_t                 tbl_key [SLOT_COUNT];
    time_t                tbl_time [SLOT_COUNT];
    bit                   tbl_known [SLOT_COUNT];
    bit                   tbl_on [SLOT_COUNT];
    logic [HOLD_BITS-1:0] hold_ms;

    verdict_t verdict_q[$];
    row_t     directed_rows[$];
    key_t     key_pool [KEY_POOL];
    key_t     last_key;
    time_t    cur_now;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    keyed_command_duplicate_filter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Look the command up in the shadow table and apply its update
    function automatic verdict_t filter_lookup(command_t c);
        verdict_t v;
        int       vacant_idx;
        int       old_idx;
        bit       have_old;
        time_t    old_t;
        bit       recent;
        bit       same;
        int       s;
        vacant_idx = -1;
        old_idx = 0;
        have_old = 1'b0;
        old_t = '0;
        v.allow = 1'b0;
        v.matched = 1'b0;
        v.slot = '0;
        if (c.empty) begin
            return v;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!tbl_used[i]) begin
                if (vacant_idx < 0) vacant_idx = i;
                continue;
            end
            if (tbl_key[i] == c.key) begin
                // time going backwards counts as a recent entry
                recent = (c.now < tbl_time[i]) || ((c.now - tbl_time[i]) < {32'd0, hold_ms});
                same = c.known && tbl_known[i] && (tbl_on[i] == c.on);
                v.matched = 1'b1;
                v.slot = i[SLOT_OUT_BITS-1:0];
                if (same && recent) begin
                    return v;
                end
                tbl_time[i] = c.now;
                tbl_known[i] = c.known;
                tbl_on[i] = c.on;
                v.allow = 1'b1;
                return v;
            end
            if (!have_old || tbl_time[i] < old_t) begin
                have_old = 1'b1;
                old_t = tbl_time[i];
                old_idx = i;
            end
        end
        // miss: lowest free slot, else the oldest entry
        s = (vacant_idx >= 0) ? vacant_idx : old_idx;
        tbl_used[s] = 1'b1;
        tbl_key[s] = c.key;
        tbl_time[s] = c.now;
        tbl_known[s] = c.known;
        tbl_on[s] = c.on;
        v.allow = 1'b1;
        v.slot = s[SLOT_OUT_BITS-1:0];
        return v;
    endfunction

    task automatic add_row(input key_t key, input logic empty, input time_t now,
                           input logic known, input logic on, input bit typed,
                           input logic allow, input logic matched, input int slot);
        row_t r;
        r.cmd.key = key;
        r.cmd.empty = empty;
        r.cmd.now = now;
        r.cmd.known = known;
        r.cmd.on = on;
        r.typed = typed;
        r.want.allow = allow;
        r.want.matched = matched;
        r.want.slot = slot[SLOT_OUT_BITS-1:0];
        directed_rows.push_back(r);
    endtask

    // Offer one command, idling first at random, and queue its verdict on acceptance
    task automatic send_command(input command_t c, input bit typed, input verdict_t want);
        logic [S_TDATA_BITS-1:0] word;
        verdict_t                v;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        word = '0;
        word[KEY_LSB +: KEY_BITS] = c.key;
        word[TIME_LSB +: TIME_BITS] = c.now;
        word[KNOWN_POS] = c.known;
        word[ON_POS] = c.on;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= c.empty;
        do @(posedge aclk); while (!s_tready);
        v = filter_lookup(c);
        verdict_q.push_back(typed ? want : v);
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_hold(input logic [HOLD_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hold_ms = value;
    endtask

    // Build a random command: mostly repeats and pooled keys, time moving around the window
    task automatic make_random(output command_t c);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) c.key = last_key;
        else if (r < 85) c.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else if (r < 92) c.key = {$urandom, $urandom};
        else if (r < 96) c.key = '0;
        else c.key = '1;
        last_key = c.key;
        r = $urandom_range(0, 99);
        if (r < 25) cur_now = cur_now;
        else if (r < 40) cur_now = cur_now + hold_ms - $urandom_range(0, 1);
        else if (r < 85) cur_now = cur_now + $urandom_range(0, int'(hold_ms) * 3 / 2 + 2);
        else if (r < 95) cur_now = cur_now - $urandom_range(1, 64);
        else if (r < 98) cur_now = {16'($urandom_range(0, 65535)), $urandom};
        else cur_now = '1 - $urandom_range(0, 3);
        c.now = cur_now;
        c.empty = ($urandom_range(0, 99) < 5);
        c.known = ($urandom_range(0, 99) < 75);
        c.on = 1'($urandom_range(0, 1));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 11;
                recv_idle_pct = 71;
            end
            1: begin
                send_idle_pct = 71;
                recv_idle_pct = 11;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic report(input string what, input verdict_t want, input verdict_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: want allow=%0b matched=%0b slot=%0d, got allow=%0b matched=%0b slot=%0d",
                     $realtime, what, want.allow, want.matched, want.slot,
                     got.allow, got.matched, got.slot);
        end
    endtask

    // Compare each result transaction with the oldest queued verdict; drive ready at random
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.allow = m_tdata[0];
            got.matched = m_tdata[1];
            got.slot = m_tdata[2 +: SLOT_OUT_BITS];
            if (verdict_q.size() == 0) begin
                want.allow = 1'bx;
                want.matched = 1'bx;
                want.slot = 'x;
                report("unexpected result", want, got);
            end else begin
                want = verdict_q.pop_front();
                if (got.allow !== want.allow || got.matched !== want.matched ||
                    got.slot !== want.slot) begin
                    report("result mismatch", want, got);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stop the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_keyed_command_duplicate_filter_unit: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        command_t                 c;
        verdict_t                 none;
        logic [HOLD_BITS-1:0]     phase_hold [PHASE_COUNT];
        none.allow = 1'b0;
        none.matched = 1'b0;
        none.slot = '0;
        hold_ms = HOLD_RESET;
        for (int i = 0; i < SLOT_COUNT; i++) tbl_used[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
        last_key = key_pool[0];
        cur_now = '0;

        // Directed rows at the reset hold window of 250 ms
        add_row('1, 1, '1, 1, 1, 1, 0, 0, 0);      // empty key, all ones elsewhere
        add_row('0, 0, '0, 1, 1, 1, 1, 0, 0);      // first key takes slot 0
        add_row('0, 0, 48'd10, 1, 1, 1, 0, 1, 0);  // same target inside window
        add_row('0, 0, 48'd249, 1, 1, 1, 0, 1, 0); // one below the window edge
        add_row('0, 0, 48'd250, 1, 1, 1, 1, 1, 0); // age equals the window
        add_row('1, 0, '1, 0, 1, 1, 1, 0, 1);      // all ones key, latest time
        add_row('1, 0, 48'd5, 1, 0, 1, 1, 1, 1);   // stored target unknown
        add_row('1, 0, 48'd6, 1, 0, 1, 0, 1, 1);   // repeat of known off
        add_row('1, 0, 48'd3, 1, 0, 1, 0, 1, 1);   // time going backwards
        add_row('1, 0, 48'd7, 0, 0, 1, 1, 1, 1);   // new target unknown
        add_row('1, 0, 48'd8, 1, 1, 1, 1, 1, 1);
        add_row('1, 0, 48'd9, 1, 0, 1, 1, 1, 1);   // target changed
        add_row('0, 1, 48'd300, 1, 1, 1, 0, 0, 0); // empty key naming a stored key
        add_row('0, 0, 48'd300, 1, 1, 1, 0, 1, 0); // entry untouched by the rejection
        for (int k = 0; k < 10; k++) begin
            add_row({32'hA5A5_5A5A, 32'(k)}, 0, 48'(k / 3), k[0], k[1], 0, 0, 0, 0);
        end

        phase_hold[0] = '0;
        phase_hold[1] = '1;
        phase_hold[2] = 16'd1;
        phase_hold[3] = 16'($urandom_range(0, 65535));
        phase_hold[4] = HOLD_RESET;
        phase_hold[5] = 16'($urandom_range(0, 65535));

        // Hold reset, then release it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0);
        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end
        s_tvalid <= 1'b0;

        // Random phases, each with its own hold window; each pair of phases shares an idling mix
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            write_hold(phase_hold[p]);
            set_idling(p / 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_random(c);
                send_command(c, 0, none);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb_keyed_command_duplicate_filter_unit: clean");
        end else begin
            $display("tb_keyed_command_duplicate_filter_unit: errors");
        end
        $finish;
    end

endmodule
